>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/nqse_pkg.sv
// ----------------------------------------------------------------------------
// nqse_pkg
// types, constants and microcode table of the n-queens enumerator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nqse_pkg;

    localparam int SIZE_W  = 5;
    localparam int PLACE_W = 64;
    localparam int COUNT_W = 24;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = PLACE_W + COUNT_W;

    localparam logic [SIZE_W-1:0] BOARD_SIZE_RST = 5'd8;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LEAVE,
        OP_TRY,
        OP_RETREAT,
        OP_EMIT
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_IN_BEAT,
        C_HELD,
        C_FIN,
        C_COL_END,
        C_LAST,
        C_ROW0,
        C_OUT_BUSY
    } t_cond;

    // microcode addresses
    typedef enum logic [2:0] {
        S_WAIT,
        S_CHK,
        S_LOOP,
        S_TRY,
        S_RETREAT,
        S_EMIT
    } t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond_a;
        t_pc   tgt_a;
        t_cond cond_b;
        t_pc   tgt_b;
        t_pc   nxt;
    } t_uword;

    // status from datapath to sequencer
    typedef struct packed {
        logic in_beat;
        logic held;
        logic fin;
        logic col_end;
        logic last_place;
        logic row_zero;
        logic out_busy;
    } t_flags;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_WAIT:    w = '{OP_ACCEPT,  C_IN_BEAT,  S_CHK,     C_NEVER, S_WAIT, S_WAIT};
            S_CHK:     w = '{OP_LEAVE,   C_HELD,     S_RETREAT, C_NEVER, S_WAIT, S_LOOP};
            S_LOOP:    w = '{OP_NONE,    C_FIN,      S_EMIT,    C_NEVER, S_WAIT, S_TRY};
            S_TRY:     w = '{OP_TRY,     C_COL_END,  S_RETREAT, C_LAST,  S_EMIT, S_TRY};
            S_RETREAT: w = '{OP_RETREAT, C_ROW0,     S_EMIT,    C_NEVER, S_WAIT, S_TRY};
            S_EMIT:    w = '{OP_EMIT,    C_OUT_BUSY, S_EMIT,    C_NEVER, S_WAIT, S_WAIT};
            default:   w = '{OP_NONE,    C_NEVER,    S_WAIT,    C_NEVER, S_WAIT, S_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/nqse_seq.sv
// ----------------------------------------------------------------------------
// nqse_seq
// microcode sequencer: step counter, table fetch and conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nqse_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nqse_pkg::t_flags i_flags,
    output nqse_pkg::t_op   o_op
);
    import nqse_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;

    function automatic logic cond_hit(input t_cond c, input t_flags f);
        logic hit;
        unique case (c)
            C_NEVER:    hit = 1'b0;
            C_IN_BEAT:  hit = f.in_beat;
            C_HELD:     hit = f.held;
            C_FIN:      hit = f.fin;
            C_COL_END:  hit = f.col_end;
            C_LAST:     hit = f.last_place;
            C_ROW0:     hit = f.row_zero;
            C_OUT_BUSY: hit = f.out_busy;
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

    assign w_uw = ucode(r_pc);
    assign o_op = w_uw.op;

    always_comb begin
        priority if (cond_hit(w_uw.cond_a, i_flags)) begin
            n_pc = w_uw.tgt_a;
        end else if (cond_hit(w_uw.cond_b, i_flags)) begin
            n_pc = w_uw.tgt_b;
        end else begin
            n_pc = w_uw.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> hdl/n_queens_solution_enumerator.sv
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator
// depth-first n-queens search, one solution per request beat
// ----------------------------------------------------------------------------
// usage
//   slave stream: one beat is one request; tdata bit 0 is restart (1 clears
//   the search and count first, 0 continues from the last solution)
//   master stream: one beat per request; tuser bit 0 is found, tdata holds
//   the placement (4-bit column per row, row 0 lowest) and the solution
//   number (or total count once the search is exhausted, with found low)
//   config: i_cfg_wr_en writes board_size; any write clears the search
// search steps
//   an accepted request runs the check and loop steps, then try steps over
//   the columns, a retreat whenever a row runs out of columns, and the emit
//   step; stepping off a held solution trades the loop step for its retreat
//   the try and retreat steps of the sequencer set the pace of the search,
//   which is data dependent
//   one request is in flight at a time; tready is high only while waiting
// reset
//   synchronous active-low; board_size returns to 8, masks all free, count 0
// stall
//   the result sits in an output register until taken; a new request may be
//   accepted meanwhile, and its result waits in the emit step for the slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module n_queens_solution_enumerator #(
    parameter int MAX_QUEENS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nqse_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] restart, rest zero
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [nqse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [63:0] placement,
                                                               // [87:64] solution_number
    output logic [0:0]                         m_axis_tuser,   // [0] found
    input  logic                               i_cfg_wr_en,
    input  logic [nqse_pkg::SIZE_W-1:0]        i_cfg_wr_data   // board_size
);
    import nqse_pkg::*;

    localparam int CW = $clog2(MAX_QUEENS);        // column index
    localparam int NW = $clog2(MAX_QUEENS + 1);    // row / column counter
    localparam int DN = 2 * MAX_QUEENS - 1;        // diagonal count
    localparam int DW = $clog2(DN);                // diagonal index

    // search state
    logic [SIZE_W-1:0]     r_bs,        n_bs;
    logic [MAX_QUEENS-1:0] r_col_free,  n_col_free;
    logic [DN-1:0]         r_diag_free, n_diag_free;
    logic [DN-1:0]         r_anti_free, n_anti_free;
    logic [CW-1:0]         r_choice [MAX_QUEENS];
    logic [CW-1:0]         n_choice [MAX_QUEENS];
    logic [NW-1:0]         r_row,       n_row;
    logic [NW-1:0]         r_col,       n_col;
    logic [COUNT_W-1:0]    r_count,     n_count;
    logic                  r_fin,       n_fin;

    // output register
    logic                  r_m_valid,   n_m_valid;
    logic                  r_m_found,   n_m_found;
    logic [PLACE_W-1:0]    r_m_place,   n_m_place;
    logic [COUNT_W-1:0]    r_m_count,   n_m_count;

    t_op    w_op;
    t_flags w_flags;

    logic [NW-1:0]   w_n;
    logic            w_clear;
    logic            w_in_beat;
    logic            w_out_busy;
    logic [CW-1:0]   w_col_idx;
    logic [DW-1:0]   w_diag_idx;
    logic [DW-1:0]   w_anti_idx;
    logic            w_free;
    logic            w_col_end;
    logic [NW-1:0]   w_row_dn;
    logic [CW-1:0]   w_prev;
    logic [DW-1:0]   w_rdiag_idx;
    logic [DW-1:0]   w_ranti_idx;
    logic [PLACE_W-1:0] w_place;

    // effective board size: zero reads as one, large sizes saturate
    always_comb begin
        priority if (r_bs == '0) begin
            w_n = NW'(1);
        end else if (r_bs > SIZE_W'(MAX_QUEENS)) begin
            w_n = NW'(MAX_QUEENS);
        end else begin
            w_n = NW'(r_bs);
        end
    end

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_busy = r_m_valid && !m_axis_tready;
    assign w_clear    = i_cfg_wr_en || (w_op == OP_ACCEPT && w_in_beat && s_axis_tdata[0]);

    // try path: candidate column in the current row
    assign w_col_end  = (r_col >= w_n);
    assign w_col_idx  = r_col[CW-1:0];
    assign w_diag_idx = DW'({1'b0, r_row} + {1'b0, w_n} - (NW+1)'(1) - {1'b0, r_col});
    assign w_anti_idx = DW'({1'b0, r_row} + {1'b0, r_col});
    assign w_free     = r_col_free[w_col_idx] && r_diag_free[w_diag_idx]
                        && r_anti_free[w_anti_idx];

    // retreat path: queen of the row above
    assign w_row_dn    = r_row - NW'(1);
    assign w_prev      = r_choice[w_row_dn[CW-1:0]];
    assign w_rdiag_idx = DW'({1'b0, w_row_dn} + {1'b0, w_n} - (NW+1)'(1)
                             - (NW+1)'(w_prev));
    assign w_ranti_idx = DW'({1'b0, w_row_dn} + (NW+1)'(w_prev));

    // gather the column of every row in use
    always_comb begin
        w_place = '0;
        for (int r = 0; r < MAX_QUEENS; r++) begin
            if (NW'(r) < w_n) begin
                w_place[4*r +: 4] = 4'(r_choice[r]);
            end
        end
    end

    always_comb begin
        w_flags.in_beat    = w_in_beat;
        w_flags.held       = !r_fin && (r_row >= w_n);
        w_flags.fin        = r_fin;
        w_flags.col_end    = w_col_end;
        w_flags.last_place = !w_col_end && w_free && ((r_row + NW'(1)) == w_n);
        w_flags.row_zero   = (r_row == '0);
        w_flags.out_busy   = w_out_busy;
    end

    nqse_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    assign s_axis_tready = (w_op == OP_ACCEPT);

    // next-state datapath driven by the current microcode op
    always_comb begin
        n_bs        = r_bs;
        n_col_free  = r_col_free;
        n_diag_free = r_diag_free;
        n_anti_free = r_anti_free;
        n_choice    = r_choice;
        n_row       = r_row;
        n_col       = r_col;
        n_count     = r_count;
        n_fin       = r_fin;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_found   = r_m_found;
        n_m_place   = r_m_place;
        n_m_count   = r_m_count;

        if (i_cfg_wr_en) begin
            n_bs = i_cfg_wr_data;
        end

        if (w_clear) begin
            n_col_free  = '1;
            n_diag_free = '1;
            n_anti_free = '1;
            n_row       = '0;
            n_col       = '0;
            n_count     = '0;
            n_fin       = 1'b0;
        end else begin
            unique case (w_op)
                OP_LEAVE: begin
                    // step off the solution reported last time
                    if (w_flags.held) begin
                        n_row = w_n;
                    end
                end
                OP_TRY: begin
                    if (!w_col_end) begin
                        if (w_free) begin
                            n_choice[r_row[CW-1:0]] = w_col_idx;
                            n_col_free[w_col_idx]   = 1'b0;
                            n_diag_free[w_diag_idx] = 1'b0;
                            n_anti_free[w_anti_idx] = 1'b0;
                            n_row = r_row + NW'(1);
                            n_col = '0;
                            if (w_flags.last_place) begin
                                n_count = r_count + COUNT_W'(1);
                            end
                        end else begin
                            n_col = r_col + NW'(1);
                        end
                    end
                end
                OP_RETREAT: begin
                    if (r_row == '0) begin
                        n_fin = 1'b1;
                    end else begin
                        n_row = w_row_dn;
                        n_col_free[w_prev]       = 1'b1;
                        n_diag_free[w_rdiag_idx] = 1'b1;
                        n_anti_free[w_ranti_idx] = 1'b1;
                        n_col = NW'(w_prev) + NW'(1);
                    end
                end
                OP_EMIT: begin
                    if (!w_out_busy) begin
                        n_m_valid = 1'b1;
                        n_m_found = !r_fin;
                        n_m_place = r_fin ? '0 : w_place;
                        n_m_count = r_count;
                    end
                end
                OP_NONE, OP_ACCEPT: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs        <= BOARD_SIZE_RST;
            r_col_free  <= '1;
            r_diag_free <= '1;
            r_anti_free <= '1;
            r_row       <= '0;
            r_col       <= '0;
            r_count     <= '0;
            r_fin       <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_bs        <= n_bs;
            r_col_free  <= n_col_free;
            r_diag_free <= n_diag_free;
            r_anti_free <= n_anti_free;
            r_row       <= n_row;
            r_col       <= n_col;
            r_count     <= n_count;
            r_fin       <= n_fin;
            r_m_valid   <= n_m_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_choice  <= n_choice;
        r_m_found <= n_m_found;
        r_m_place <= n_m_place;
        r_m_count <= n_m_count;
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = {r_m_count, r_m_place};
    assign m_axis_tuser[0] = r_m_found;

endmodule

>>> hdl/nqse_chk.sv
// ----------------------------------------------------------------------------
// nqse_chk
// port-level checks of the n-queens enumerator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nqse_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [nqse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                       m_axis_tuser
);

    // stalled result beat holds
    `CHK_NXT(a_out_hold, i_clk,
        i_rst_n && m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")

    // exhausted search carries an empty placement
    `CHK_IMP(a_exhaust_empty, i_clk,
        m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[63:0] == 64'd0,
        "placement not empty on exhausted search")

    // a reported solution has a nonzero index
    `CHK_IMP(a_found_index, i_clk,
        m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[87:64] != 24'd0,
        "solution reported with index zero")

    // reset empties the output slot
    `CHK_NXT(a_rst_empty, i_clk,
        !i_rst_n,
        !m_axis_tvalid,
        "result valid after reset")

endmodule

bind n_queens_solution_enumerator nqse_chk u_nqse_chk (.*);

>>> verif/tb_n_queens_solution_enumerator.sv
// ----------------------------------------------------------------------------
// tb_n_queens_solution_enumerator
// self-checking bench for the depth-first n-queens enumerator
// ----------------------------------------------------------------------------
// A scoreboard class runs its own backtracking search alongside the block.
// Every accepted request beat advances that search by one solution, or finds
// it exhausted, and queues the beat the block should return. Every result
// beat is checked field by field against the oldest queued one. Stimulus is a
// short directed run over the board-size extremes, restarts and exhausted
// searches, then random phases of board sizes up to 13 with random restarts. Both
// streams idle in random bursts until a final burst-free phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_n_queens_solution_enumerator;

    import nqse_pkg::*;

    localparam int MAX_QUEENS     = 16;
    localparam int RANDOM_TARGET  = 1600;       // requests before the last phase
    localparam int CALM_REQUESTS  = 150;        // requests in the burst-free phase
    localparam int SETTLE_CYCLES  = 8;          // after the last result of a phase
    localparam int QUIET_LIMIT    = 4_000_000;  // cycles without any beat

    // one result beat as the block presents it
    typedef struct packed {
        logic               found;
        logic [PLACE_W-1:0] placement;
        logic [COUNT_W-1:0] number;
    } t_solution;

    // shadow search plus the queue of result beats still owed by the block
    class solution_tracker;
        bit [SIZE_W-1:0] size_reg;
        bit [15:0]       col_free;
        bit [30:0]       diag_free;
        bit [30:0]       anti_free;
        bit [3:0]        row_pick [16];
        int unsigned     row;
        int unsigned     next_col;
        bit [COUNT_W-1:0] count;
        bit              exhausted;
        t_solution       pending_solutions [$];
        int              failures;

        function new();
            size_reg = BOARD_SIZE_RST;
            foreach (row_pick[i]) row_pick[i] = '0;
            failures = 0;
            clear_search();
        endfunction

        function void clear_search();
            col_free  = '1;
            diag_free = '1;
            anti_free = '1;
            row       = 0;
            next_col  = 0;
            count     = '0;
            exhausted = 1'b0;
        endfunction

        // zero acts as one, anything past the largest board saturates
        function int unsigned board_n();
            int unsigned n;
            n = size_reg;
            if (n < 1) n = 1;
            if (n > MAX_QUEENS) n = MAX_QUEENS;
            return n;
        endfunction

        function void set_board_size(bit [SIZE_W-1:0] v);
            size_reg = v;
            clear_search();
        endfunction

        // lift the queen of the row above, flags exhaustion at the top row
        function bit back_off(int unsigned n);
            int unsigned c;
            if (row == 0) begin
                exhausted = 1'b1;
                return 1'b0;
            end
            row--;
            c = row_pick[row & 15];
            col_free[c]                      = 1'b1;
            diag_free[(row + n - 1 - c) & 31] = 1'b1;
            anti_free[(row + c) & 31]        = 1'b1;
            next_col = c + 1;
            return 1'b1;
        endfunction

        function void note_request(bit restart);
            int unsigned n, c, d, a;
            bit          placed;
            t_solution   s;
            n = board_n();
            s = '0;
            if (restart) clear_search();
            // a solution is still held: step off it first
            if (!exhausted && row >= n) begin
                row = n;
                void'(back_off(n));
            end
            while (!exhausted) begin
                c      = next_col;
                placed = 1'b0;
                while (c < n && !placed) begin
                    d = (row + n - 1 - c) & 31;
                    a = (row + c) & 31;
                    if (col_free[c] && diag_free[d] && anti_free[a]) begin
                        row_pick[row & 15] = c[3:0];
                        col_free[c]  = 1'b0;
                        diag_free[d] = 1'b0;
                        anti_free[a] = 1'b0;
                        row++;
                        next_col = 0;
                        placed   = 1'b1;
                    end else begin
                        c++;
                    end
                end
                if (placed) begin
                    if (row == n) begin
                        count++;
                        s.found = 1'b1;
                        for (int r = 0; r < n; r++) s.placement[4*r +: 4] = row_pick[r];
                        s.number = count;
                        pending_solutions.push_back(s);
                        return;
                    end
                end else if (!back_off(n)) begin
                    break;
                end
            end
            // exhausted: no placement, total count
            s.number = count;
            pending_solutions.push_back(s);
        endfunction

        function void check_solution(t_solution got);
            t_solution want;
            if (pending_solutions.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result beat with nothing pending: found %0b place %h num %0d",
                             $realtime, got.found, got.placement, got.number);
                return;
            end
            want = pending_solutions.pop_front();
            if (got.found !== want.found || got.placement !== want.placement ||
                got.number !== want.number) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch found %0b/%0b place %h/%h num %0d/%0d (exp/act)",
                             $realtime, want.found, got.found, want.placement,
                             got.placement, want.number, got.number);
            end
        endfunction

        function int pending_count();
            return pending_solutions.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [0] restart, rest zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [63:0] placement, [87:64] solution_number
    logic [0:0]             m_axis_tuser;   // [0] found
    logic                   i_cfg_wr_en;
    logic [SIZE_W-1:0]      i_cfg_wr_data;  // board_size

    solution_tracker tracker = new();

    int  requests_sent;
    bit  calm;           // set for the last phase: no idling on either side
    bit  phase_gaps;     // sender gaps allowed in the current phase

    n_queens_solution_enumerator #(
        .MAX_QUEENS (MAX_QUEENS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result beats are checked as they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_solution(t_solution'{m_axis_tuser[0], m_axis_tdata[63:0],
                                               m_axis_tdata[64 +: COUNT_W]});
    end

    // hang detection: any beat on either stream resets the count
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: ready stretches broken by stall bursts, steady once calm
    initial begin
        int k;
        m_axis_tready = 1'b0;
        forever begin
            if (calm) begin
                @(negedge i_clk) m_axis_tready <= 1'b1;
            end else begin
                k = $urandom_range(0, 7) == 0 ? $urandom_range(40, 200) : $urandom_range(1, 30);
                repeat (k) @(negedge i_clk) m_axis_tready <= 1'b1;
                if ($urandom_range(0, 2) != 0) begin
                    k = $urandom_range(1, 14);
                    repeat (k) @(negedge i_clk) m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // one request beat; valid is left high so a following request goes
    // out back to back, the next gap or drain lowers it
    task automatic send_request(bit restart);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        tracker.note_request(restart);
        requests_sent++;
    endtask

    task automatic sender_pause(int k);
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        repeat (k - 1) @(negedge i_clk);
    endtask

    // random gap in front of a request while idling is allowed
    task automatic request_with_gap(bit restart);
        if (!calm && phase_gaps && $urandom_range(0, 3) == 0)
            sender_pause($urandom_range(1, 14));
        send_request(restart);
    endtask

    // hold off until every owed beat has come back, then let the block settle
    task automatic wait_for_results();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_board_size(bit [SIZE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        tracker.set_board_size(v);
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int pick, reqs;
        bit [SIZE_W-1:0] size_v;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        calm          = 1'b0;
        phase_gaps    = 1'b1;
        requests_sent = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset size of eight: first solution, restart onto it again, then next
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_for_results();

        // size zero acts as one: a single solution, then exhausted answers,
        // then a restart finds it again
        write_board_size('0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        wait_for_results();

        // boards with no solution at all
        write_board_size(5'd2);
        send_request(1'b0);
        wait_for_results();
        write_board_size(5'd3);
        send_request(1'b0);
        wait_for_results();

        // four queens: both solutions, exhausted twice, restart
        write_board_size(5'd4);
        repeat (4) send_request(1'b0);
        send_request(1'b1);
        wait_for_results();

        // largest board, then an oversized write that saturates to it
        write_board_size(5'd16);
        send_request(1'b0);
        send_request(1'b0);
        wait_for_results();
        write_board_size(5'd31);
        send_request(1'b0);
        wait_for_results();

        // random phases, each starting from an idle block
        while (requests_sent < RANDOM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                size_v = SIZE_W'($urandom_range(4, 8));
                reqs   = $urandom_range(5, 110);
            end else if (pick < 17) begin
                size_v = SIZE_W'($urandom_range(0, 3));
                reqs   = $urandom_range(2, 8);
            end else begin
                // bigger boards are slow to search, keep them short
                size_v = SIZE_W'($urandom_range(9, 13));
                reqs   = $urandom_range(1, 4);
            end
            // some phases carry on with the size and search already in place
            if ($urandom_range(0, 3) != 0 || tracker.board_n() > 8)
                write_board_size(size_v);
            phase_gaps = ($urandom_range(0, 3) != 0);
            repeat (reqs) request_with_gap($urandom_range(0, 11) == 0);
            wait_for_results();
        end

        // last phase: no idling anywhere
        calm = 1'b1;
        write_board_size(SIZE_W'($urandom_range(6, 8)));
        repeat (CALM_REQUESTS) send_request($urandom_range(0, 29) == 0);

        wait_for_results();
        if (tracker.failures == 0 && tracker.pending_count() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
